>>> sv/cv2_pkg.sv
// Shared constants, types and a helper function for the 3x3 convolution block.
package cv2_pkg;

   localparam int MaxWidth     = 1024;
   localparam int MaxHeight    = 4096;
   localparam int BorderMax    = 2;
   localparam int StepMax      = 4;
   localparam int CoefBits     = 16;
   localparam int SlotBits     = 16;
   localparam int PixBits      = 8;
   localparam int ValueBits    = 28;
   localparam int RowBits      = 13;
   localparam int ColBits      = 11;
   localparam int BorderBits   = 2;
   localparam int StepBits     = 3;
   localparam int CoefRowBits  = 3 * SlotBits;
   localparam int AddrBits     = $clog2(MaxWidth);
   localparam int ProdBits     = CoefBits + PixBits + 1;
   localparam int CsrIndexBits = 3;
   localparam int RspDataBits  = ((ValueBits + RowBits + ColBits + 7) / 8) * 8;

   typedef enum logic [CsrIndexBits-1:0] {
      CsrWidth   = 3'd0,
      CsrHeight  = 3'd1,
      CsrBorder  = 3'd2,
      CsrStep    = 3'd3,
      CsrCoefTop = 3'd4,
      CsrCoefMid = 3'd5,
      CsrCoefBot = 3'd6
   } csr_index_type;

   typedef logic [8:0][PixBits-1:0] window_type;
   typedef logic [2:0][CoefRowBits-1:0] coef_rows_type;

   typedef struct packed {
      logic [RowBits-1:0] out_row;
      logic [ColBits-1:0] out_col;
      logic               last;
   } meta_type;

   // Stride grid tracking for a window corner: remainder and quotient of (pos - 2) / step.
   typedef struct packed {
      logic [1:0]         m;
      logic [RowBits-1:0] q;
   } grid_type;

   function automatic grid_type grid_next(input logic [RowBits-1:0] pos_next,
                                          input grid_type g,
                                          input logic [StepBits-1:0] step);
      grid_type            r;
      logic [StepBits-1:0] m1;
      r  = g;
      m1 = StepBits'(g.m) + StepBits'(1);
      if (pos_next <= RowBits'(2)) begin
         r.m = '0;
         r.q = '0;
      end else if (m1 == step) begin
         r.m = '0;
         r.q = g.q + RowBits'(1);
      end else begin
         r.m = m1[1:0];
      end
      return r;
   endfunction

endpackage

>>> sv/cv2_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module cv2_ram #(
   parameter int Width = 8,
   parameter int Depth = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/cv2_mac.sv
// Two-stage multiply-accumulate for one 3x3 window, ending in the result register.
module cv2_mac (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               in_valid,
   output logic                               in_ready,
   input  cv2_pkg::window_type                window,
   input  cv2_pkg::meta_type                  meta,
   input  cv2_pkg::coef_rows_type             coef_rows,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [cv2_pkg::RspDataBits-1:0]    rsp_tdata,  // value, out_row, out_col
   output logic                               rsp_tlast
);

   logic signed [cv2_pkg::ProdBits-1:0]  prod_in [9];
   logic signed [cv2_pkg::ProdBits-1:0]  prod_ff [9];
   cv2_pkg::meta_type                    meta_a_ff;
   logic                                 va_ff;
   logic                                 va_in;
   logic signed [cv2_pkg::ValueBits-1:0] sum_in;
   logic signed [cv2_pkg::ValueBits-1:0] value_ff;
   cv2_pkg::meta_type                    meta_b_ff;
   logic                                 vb_ff;
   logic                                 vb_in;
   logic                                 out_ready;
   logic                                 a_ready;

   assign out_ready = !vb_ff || rsp_tready;
   assign a_ready   = !va_ff || out_ready;
   assign in_ready  = a_ready;

   for (genvar k = 0; k < 9; k++) begin : g_prod
      assign prod_in[k] =
         $signed(coef_rows[k / 3][(k % 3) * cv2_pkg::SlotBits +: cv2_pkg::CoefBits]) *
         $signed({1'b0, window[k]});
   end

   always_comb begin
      sum_in = '0;
      for (int k = 0; k < 9; k++) begin
         sum_in = sum_in + cv2_pkg::ValueBits'(prod_ff[k]);
      end
   end

   assign va_in = a_ready ? in_valid : va_ff;
   assign vb_in = out_ready ? va_ff : vb_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
      end else begin
         va_ff <= va_in;
         vb_ff <= vb_in;
      end
   end

   always_ff @(posedge clock) begin
      if (a_ready && in_valid) begin
         prod_ff   <= prod_in;
         meta_a_ff <= meta;
      end
      if (out_ready && va_ff) begin
         value_ff  <= sum_in;
         meta_b_ff <= meta_a_ff;
      end
   end

   assign rsp_tvalid = vb_ff;
   assign rsp_tdata  = cv2_pkg::RspDataBits'({meta_b_ff.out_col, meta_b_ff.out_row, value_ff});
   assign rsp_tlast  = meta_b_ff.last;

endmodule

>>> sv/conv2d_3x3_stride_pad.sv
// 3x3 convolution over a zero-padded pixel stream with stride, two line memories.
// An accepted transfer is registered in the window stage, then in the MAC product and result registers.
// Throughput: one pixel per cycle unless the MAC stalls; a pixel that ends a row holds the
// window shifter for one extra shift per right-border column, one result slot per column.
// Output stalls back up through the MAC stages to req_tready.
// Reset: synchronous; control registers reset, pipeline data and line memories do not.
module conv2d_3x3_stride_pad (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [cv2_pkg::PixBits-1:0]           req_tdata,  // pixel
   input  logic                                  req_tuser,  // op
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [cv2_pkg::RspDataBits-1:0]       rsp_tdata,  // value, out_row, out_col
   output logic                                  rsp_tlast,  // last
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [cv2_pkg::CsrIndexBits-1:0]      csr_index,
   input  logic [cv2_pkg::CoefRowBits-1:0]       csr_data
);

   // configuration
   logic [cv2_pkg::ColBits-1:0]    w_ff, w_in;
   logic [cv2_pkg::RowBits-1:0]    h_ff, h_in;
   logic [cv2_pkg::BorderBits-1:0] b_ff, b_in;
   logic [cv2_pkg::StepBits-1:0]   s_ff, s_in;
   cv2_pkg::coef_rows_type         coef_ff, coef_in;
   cv2_pkg::csr_index_type         csr_sel;
   logic                           csr_write;
   logic                           restart;

   // input position
   logic [cv2_pkg::RowBits-1:0]    row_ff, row_in;
   logic [cv2_pkg::ColBits-1:0]    col_ff, col_in;
   cv2_pkg::grid_type              rg_ff, rg_in;

   // window stage
   logic                           s1_v_ff, s1_v_in;
   logic [cv2_pkg::PixBits-1:0]    s1_pix_ff;
   logic                           s1_top_en_ff;
   logic                           s1_mid_en_ff;
   logic [cv2_pkg::AddrBits-1:0]   s1_x_ff;
   logic [cv2_pkg::RowBits-1:0]    s1_row_ff;
   logic [cv2_pkg::ColBits-1:0]    s1_col_ff;
   cv2_pkg::grid_type              s1_rg_ff;
   logic [cv2_pkg::BorderBits-1:0] s1_tail_ff;
   logic                           s1_rowstart_ff;
   logic [cv2_pkg::BorderBits-1:0] ph_ff, ph_in;
   cv2_pkg::window_type            win_ff;
   cv2_pkg::window_type            win_in;
   logic [cv2_pkg::ColBits-1:0]    ccol_ff;
   cv2_pkg::grid_type              cg_ff;

   // read-after-write bypass
   logic                           fwd_ff;
   logic [cv2_pkg::PixBits-1:0]    fwd0_ff;
   logic [cv2_pkg::PixBits-1:0]    fwd1_ff;

   logic [cv2_pkg::RowBits-1:0]    hp;
   logic [cv2_pkg::ColBits-1:0]    wp;
   logic                           rowend;
   logic                           accept;
   logic [cv2_pkg::AddrBits-1:0]   x_now;
   logic [cv2_pkg::PixBits-1:0]    pix_now;
   logic                           step;
   logic                           main_step;
   logic                           done;
   logic                           mac_ready;
   logic [cv2_pkg::PixBits-1:0]    ram0_rd, ram1_rd, rd0, rd1;
   logic [2:0][cv2_pkg::PixBits-1:0] new_col;
   cv2_pkg::window_type            base_win;
   logic [cv2_pkg::ColBits-1:0]    c_now;
   cv2_pkg::grid_type              cg_now;
   logic                           emit;
   logic                           last_now;
   cv2_pkg::meta_type              meta_now;
   logic                           ram_we;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;
   assign csr_sel   = cv2_pkg::csr_index_type'(csr_index);

   always_comb begin
      w_in    = w_ff;
      h_in    = h_ff;
      b_in    = b_ff;
      s_in    = s_ff;
      coef_in = coef_ff;
      restart = 1'b0;
      if (csr_write) begin
         case (csr_sel)
            cv2_pkg::CsrWidth: begin
               restart = 1'b1;
               if (csr_data[cv2_pkg::ColBits-1:0] == '0) begin
                  w_in = cv2_pkg::ColBits'(1);
               end else if (csr_data[cv2_pkg::ColBits-1:0] >
                            cv2_pkg::ColBits'(cv2_pkg::MaxWidth)) begin
                  w_in = cv2_pkg::ColBits'(cv2_pkg::MaxWidth);
               end else begin
                  w_in = csr_data[cv2_pkg::ColBits-1:0];
               end
            end
            cv2_pkg::CsrHeight: begin
               restart = 1'b1;
               if (csr_data[cv2_pkg::RowBits-1:0] == '0) begin
                  h_in = cv2_pkg::RowBits'(1);
               end else if (csr_data[cv2_pkg::RowBits-1:0] >
                            cv2_pkg::RowBits'(cv2_pkg::MaxHeight)) begin
                  h_in = cv2_pkg::RowBits'(cv2_pkg::MaxHeight);
               end else begin
                  h_in = csr_data[cv2_pkg::RowBits-1:0];
               end
            end
            cv2_pkg::CsrBorder: begin
               restart = 1'b1;
               if (csr_data[cv2_pkg::BorderBits-1:0] >
                   cv2_pkg::BorderBits'(cv2_pkg::BorderMax)) begin
                  b_in = cv2_pkg::BorderBits'(cv2_pkg::BorderMax);
               end else begin
                  b_in = csr_data[cv2_pkg::BorderBits-1:0];
               end
            end
            cv2_pkg::CsrStep: begin
               restart = 1'b1;
               if (csr_data[cv2_pkg::StepBits-1:0] == '0) begin
                  s_in = cv2_pkg::StepBits'(1);
               end else if (csr_data[cv2_pkg::StepBits-1:0] >
                            cv2_pkg::StepBits'(cv2_pkg::StepMax)) begin
                  s_in = cv2_pkg::StepBits'(cv2_pkg::StepMax);
               end else begin
                  s_in = csr_data[cv2_pkg::StepBits-1:0];
               end
            end
            cv2_pkg::CsrCoefTop: coef_in[0] = csr_data;
            cv2_pkg::CsrCoefMid: coef_in[1] = csr_data;
            cv2_pkg::CsrCoefBot: coef_in[2] = csr_data;
            default: ;
         endcase
      end
   end

   assign hp     = h_ff + cv2_pkg::RowBits'({b_ff, 1'b0});
   assign wp     = w_ff + cv2_pkg::ColBits'({b_ff, 1'b0});
   assign rowend = col_ff == (w_ff + cv2_pkg::ColBits'(b_ff) - cv2_pkg::ColBits'(1));
   assign accept = req_tvalid && req_tready;
   assign x_now  = cv2_pkg::AddrBits'(col_ff - cv2_pkg::ColBits'(b_ff));
   assign pix_now = (!req_tuser && row_ff < h_ff + cv2_pkg::RowBits'(b_ff)) ? req_tdata : '0;

   // position of the next input transfer
   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      rg_in  = rg_ff;
      if (restart) begin
         row_in = cv2_pkg::RowBits'(b_in);
         col_in = cv2_pkg::ColBits'(b_in);
         rg_in  = '0;
      end else if (accept) begin
         if (rowend) begin
            col_in = cv2_pkg::ColBits'(b_ff);
            if (row_ff + cv2_pkg::RowBits'(1) >= hp) begin
               row_in = cv2_pkg::RowBits'(b_ff);
               rg_in  = '0;
            end else begin
               row_in = row_ff + cv2_pkg::RowBits'(1);
               rg_in  = cv2_pkg::grid_next(row_in, rg_ff, s_ff);
            end
         end else begin
            col_in = col_ff + cv2_pkg::ColBits'(1);
         end
      end
   end

   // window stage: one main shift per pixel, then one zero shift per right-border column
   assign step      = s1_v_ff && mac_ready;
   assign main_step = ph_ff == '0;
   assign done      = step && (ph_ff == s1_tail_ff);
   assign req_tready = !s1_v_ff || done;
   assign s1_v_in   = accept ? 1'b1 : (done ? 1'b0 : s1_v_ff);
   assign ph_in     = step ? (done ? '0 : ph_ff + cv2_pkg::BorderBits'(1)) : ph_ff;

   assign rd0 = fwd_ff ? fwd0_ff : ram0_rd;
   assign rd1 = fwd_ff ? fwd1_ff : ram1_rd;

   always_comb begin
      if (main_step) begin
         new_col[0] = s1_top_en_ff ? rd1 : '0;
         new_col[1] = s1_mid_en_ff ? rd0 : '0;
         new_col[2] = s1_pix_ff;
      end else begin
         new_col = '0;
      end
      base_win = (main_step && s1_rowstart_ff) ? '0 : win_ff;
      for (int r = 0; r < 3; r++) begin
         win_in[r * 3 + 0] = base_win[r * 3 + 1];
         win_in[r * 3 + 1] = base_win[r * 3 + 2];
         win_in[r * 3 + 2] = new_col[r];
      end
   end

   assign c_now    = main_step ? s1_col_ff : ccol_ff + cv2_pkg::ColBits'(1);
   assign cg_now   = cv2_pkg::grid_next(cv2_pkg::RowBits'(c_now), cg_ff, s_ff);
   assign emit     = (s1_row_ff >= cv2_pkg::RowBits'(2)) && (c_now >= cv2_pkg::ColBits'(2)) &&
                     (s1_rg_ff.m == '0) && (cg_now.m == '0);
   assign last_now = ({1'b0, s1_row_ff} + (cv2_pkg::RowBits + 1)'(s_ff) >= {1'b0, hp}) &&
                     ({1'b0, c_now} + (cv2_pkg::ColBits + 1)'(s_ff) >= {1'b0, wp});
   assign meta_now = '{out_row: s1_rg_ff.q,
                       out_col: cg_now.q[cv2_pkg::ColBits-1:0],
                       last:    last_now};
   assign ram_we   = step && main_step;

   always_ff @(posedge clock) begin
      if (reset) begin
         w_ff    <= cv2_pkg::ColBits'(cv2_pkg::MaxWidth);
         h_ff    <= cv2_pkg::RowBits'(1024);
         b_ff    <= cv2_pkg::BorderBits'(1);
         s_ff    <= cv2_pkg::StepBits'(1);
         coef_ff <= '0;
         row_ff  <= cv2_pkg::RowBits'(1);
         col_ff  <= cv2_pkg::ColBits'(1);
         rg_ff   <= '0;
         s1_v_ff <= 1'b0;
         ph_ff   <= '0;
         fwd_ff  <= 1'b0;
      end else begin
         w_ff    <= w_in;
         h_ff    <= h_in;
         b_ff    <= b_in;
         s_ff    <= s_in;
         coef_ff <= coef_in;
         row_ff  <= row_in;
         col_ff  <= col_in;
         rg_ff   <= rg_in;
         s1_v_ff <= s1_v_in;
         ph_ff   <= ph_in;
         if (accept) begin
            fwd_ff <= ram_we && (x_now == s1_x_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pix_ff      <= pix_now;
         s1_top_en_ff   <= row_ff >= cv2_pkg::RowBits'(b_ff) + cv2_pkg::RowBits'(2);
         s1_mid_en_ff   <= row_ff >= cv2_pkg::RowBits'(b_ff) + cv2_pkg::RowBits'(1);
         s1_x_ff        <= x_now;
         s1_row_ff      <= row_ff;
         s1_col_ff      <= col_ff;
         s1_rg_ff       <= rg_ff;
         s1_tail_ff     <= rowend ? b_ff : '0;
         s1_rowstart_ff <= col_ff == cv2_pkg::ColBits'(b_ff);
         fwd0_ff        <= s1_pix_ff;
         fwd1_ff        <= rd0;
      end
      if (step) begin
         win_ff  <= win_in;
         ccol_ff <= c_now;
         cg_ff   <= cg_now;
      end
   end

   // line memory 0 holds the previous row, line memory 1 the row before it
   cv2_ram #(.Width(cv2_pkg::PixBits), .Depth(cv2_pkg::MaxWidth)) u_line0 (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (s1_x_ff),
      .wr_data (s1_pix_ff),
      .rd_en   (accept),
      .rd_addr (x_now),
      .rd_data (ram0_rd)
   );

   cv2_ram #(.Width(cv2_pkg::PixBits), .Depth(cv2_pkg::MaxWidth)) u_line1 (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (s1_x_ff),
      .wr_data (rd0),
      .rd_en   (accept),
      .rd_addr (x_now),
      .rd_data (ram1_rd)
   );

   cv2_mac u_mac (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (step && emit),
      .in_ready   (mac_ready),
      .window     (win_in),
      .meta       (meta_now),
      .coef_rows  (coef_ff),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

`ifndef SYNTHESIS
   a_fwd_only_narrow: assert property (@(posedge clock) disable iff (reset)
      (accept && ram_we && x_now == s1_x_ff) |-> (w_ff == cv2_pkg::ColBits'(1)))
      else $error("same-address bypass with image width above one");

   a_col_range: assert property (@(posedge clock) disable iff (reset)
      (col_ff >= cv2_pkg::ColBits'(b_ff)) &&
      ({1'b0, col_ff} < {1'b0, w_ff} + (cv2_pkg::ColBits + 1)'(b_ff)))
      else $error("input column outside real pixel span");

   a_row_range: assert property (@(posedge clock) disable iff (reset)
      (row_ff >= cv2_pkg::RowBits'(b_ff)) && (row_ff < hp))
      else $error("input row outside padded frame");

   a_phase_bound: assert property (@(posedge clock) disable iff (reset)
      s1_v_ff |-> (ph_ff <= s1_tail_ff))
      else $error("window shifter ran past the right border");
`endif

endmodule

>>> test/cv2_test_pkg.sv
`timescale 1ns / 100ps
// Item codes shared by the convolution testbench top and its checker.
package cv2_test_pkg;

   typedef enum logic {
      OpPixel = 1'b0,
      OpFlush = 1'b1
   } pixel_op_type;

endpackage

>>> test/conv_sum_checker.sv
`timescale 1ns / 100ps
// Checker for the 3x3 convolution block: tracks registers, predicts window sums, compares results.
module conv_sum_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   input  logic [cv2_pkg::PixBits-1:0]      req_tdata,
   input  logic                             req_tuser,
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic [cv2_pkg::RspDataBits-1:0]  rsp_tdata,
   input  logic                             rsp_tlast,
   input  logic                             csr_valid,
   input  logic                             csr_ready,
   input  logic [cv2_pkg::CsrIndexBits-1:0] csr_index,
   input  logic [cv2_pkg::CoefRowBits-1:0]  csr_data,
   output int                               mismatches,
   output int                               sums_due,
   output int                               sums_checked
);
   import cv2_pkg::*;
   import cv2_test_pkg::*;

   typedef struct packed {
      logic [ValueBits-1:0] value;
      logic [RowBits-1:0]   out_row;
      logic [ColBits-1:0]   out_col;
      logic                 last;
   } window_sum_type;

   window_sum_type expected_sums[$];

   logic [ColBits-1:0]     width_reg;
   logic [RowBits-1:0]     height_reg;
   logic [BorderBits-1:0]  border_reg;
   logic [StepBits-1:0]    step_reg;
   logic [CoefRowBits-1:0] coef_reg [3];

   logic [PixBits-1:0] row_mem [2*MaxWidth];
   logic [PixBits-1:0] win [9];
   int                 pad_row;
   int                 pad_col;

   initial begin
      mismatches   = 0;
      sums_due     = 0;
      sums_checked = 0;
   end

   function automatic int clamp(input int v, input int lo, input int hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   function automatic int width_eff();
      return clamp(int'(width_reg), 1, MaxWidth);
   endfunction

   function automatic int height_eff();
      return clamp(int'(height_reg), 1, MaxHeight);
   endfunction

   function automatic int border_eff();
      return clamp(int'(border_reg), 0, BorderMax);
   endfunction

   function automatic int step_eff();
      return clamp(int'(step_reg), 1, StepMax);
   endfunction

   function automatic int coef_at(input int i, input int j);
      logic [SlotBits-1:0]        slot;
      logic signed [CoefBits-1:0] c;
      slot = coef_reg[i][SlotBits*j +: SlotBits];
      c    = slot[CoefBits-1:0];
      return c;
   endfunction

   task automatic restart_frame();
      pad_row = border_eff();
      pad_col = border_eff();
      foreach (win[i]) win[i] = '0;
   endtask

   task automatic reset_model();
      width_reg  = ColBits'(MaxWidth);
      height_reg = RowBits'(1024);
      border_reg = BorderBits'(1);
      step_reg   = StepBits'(1);
      foreach (coef_reg[i]) coef_reg[i] = '0;
      foreach (row_mem[i]) row_mem[i] = '0;
      expected_sums.delete();
      restart_frame();
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CoefRowBits-1:0] data);
      case (idx)
         CsrWidth: begin
            width_reg = data[ColBits-1:0];
            restart_frame();
         end
         CsrHeight: begin
            height_reg = data[RowBits-1:0];
            restart_frame();
         end
         CsrBorder: begin
            border_reg = data[BorderBits-1:0];
            restart_frame();
         end
         CsrStep: begin
            step_reg = data[StepBits-1:0];
            restart_frame();
         end
         CsrCoefTop: coef_reg[0] = data;
         CsrCoefMid: coef_reg[1] = data;
         CsrCoefBot: coef_reg[2] = data;
         default: ;
      endcase
   endtask

   task automatic shift_column(input logic [PixBits-1:0] t, input logic [PixBits-1:0] m,
                               input logic [PixBits-1:0] bt);
      for (int r = 0; r < 3; r++) begin
         win[r*3]   = win[r*3+1];
         win[r*3+1] = win[r*3+2];
      end
      win[2] = t;
      win[5] = m;
      win[8] = bt;
   endtask

   // window ends at padded (row, col); queue a sum when its corner is on the stride grid
   task automatic emit_if_on_grid(input int row, input int col);
      int             s, hp, wp, r0, c0, sum;
      window_sum_type e;
      s  = step_eff();
      hp = height_eff() + 2 * border_eff();
      wp = width_eff() + 2 * border_eff();
      if (row < 2 || col < 2 || hp < 3 || wp < 3) return;
      r0 = row - 2;
      c0 = col - 2;
      if (r0 % s != 0 || c0 % s != 0 || r0 > hp - 3 || c0 > wp - 3) return;
      sum = 0;
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++)
            sum += coef_at(i, j) * int'(win[i*3+j]);
      e.value   = sum[ValueBits-1:0];
      e.out_row = RowBits'(r0 / s);
      e.out_col = ColBits'(c0 / s);
      e.last    = (r0 + s > hp - 3) && (c0 + s > wp - 3);
      expected_sums.push_back(e);
   endtask

   task automatic take_item(input pixel_op_type op, input logic [PixBits-1:0] pixel);
      int                 w, h, b, hp, row, col, x;
      logic [PixBits-1:0] pix, top, mid;
      w  = width_eff();
      h  = height_eff();
      b  = border_eff();
      hp = h + 2 * b;
      if (pad_row < b || pad_row >= hp || pad_col < b || pad_col >= w + b) restart_frame();
      row = pad_row;
      col = pad_col;
      x   = (col - b) % MaxWidth;
      pix = (op == OpPixel && row < h + b) ? pixel : '0;
      top = (row >= b + 2) ? row_mem[MaxWidth + x] : '0;
      mid = (row >= b + 1) ? row_mem[x] : '0;
      row_mem[MaxWidth + x] = row_mem[x];
      row_mem[x]            = pix;
      if (col == b) foreach (win[i]) win[i] = '0;
      shift_column(top, mid, pix);
      emit_if_on_grid(row, col);
      if (col == w + b - 1) begin
         // right border columns are closed out by the last pixel of the row
         for (int k = 1; k <= b; k++) begin
            shift_column('0, '0, '0);
            emit_if_on_grid(row, col + k);
         end
         pad_col = b;
         pad_row = (row + 1 >= hp) ? b : row + 1;
      end else begin
         pad_col = col + 1;
      end
   endtask

   task automatic report_mismatch(input string what);
      if (mismatches < 50) $display("%0t mismatch: %s", $time, what);
      mismatches++;
   endtask

   always @(posedge clock) begin : watch
      window_sum_type got, want;
      if (reset) begin
         reset_model();
      end else begin
         if (csr_valid && csr_ready) write_reg(csr_index_type'(csr_index), csr_data);
         if (req_tvalid && req_tready) take_item(pixel_op_type'(req_tuser), req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            got.value   = rsp_tdata[ValueBits-1:0];
            got.out_row = rsp_tdata[ValueBits +: RowBits];
            got.out_col = rsp_tdata[ValueBits+RowBits +: ColBits];
            got.last    = rsp_tlast;
            if (expected_sums.size() == 0) begin
               report_mismatch($sformatf("unexpected sum at (%0d,%0d) value %h",
                                         got.out_row, got.out_col, got.value));
            end else begin
               want = expected_sums.pop_front();
               sums_checked++;
               if (got.value !== want.value)
                  report_mismatch($sformatf("sum (%0d,%0d) value %h, expected %h",
                                            want.out_row, want.out_col, got.value, want.value));
               if (got.out_row !== want.out_row)
                  report_mismatch($sformatf("out_row %0d, expected %0d",
                                            got.out_row, want.out_row));
               if (got.out_col !== want.out_col)
                  report_mismatch($sformatf("out_col %0d, expected %0d",
                                            got.out_col, want.out_col));
               if (got.last !== want.last)
                  report_mismatch($sformatf("sum (%0d,%0d) last %b, expected %b",
                                            want.out_row, want.out_col, got.last, want.last));
            end
         end
      end
      sums_due = expected_sums.size();
   end

endmodule

>>> test/tb.sv
`timescale 1ns / 100ps
// Testbench top for the 3x3 convolution block: clock, reset, stimulus phases and verdict.
module tb;
   import cv2_pkg::*;
   import cv2_test_pkg::*;

   localparam int DrainCycles = 12;
   localparam int QuietLimit  = 2000;

   logic                    clock      = 1'b0;
   logic                    reset      = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [PixBits-1:0]      req_tdata  = '0;
   logic                    req_tuser  = 1'b0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b1;
   logic [RspDataBits-1:0]  rsp_tdata;
   logic                    rsp_tlast;
   logic                    csr_valid  = 1'b0;
   logic                    csr_ready;
   logic [CsrIndexBits-1:0] csr_index  = '0;
   logic [CoefRowBits-1:0]  csr_data   = '0;

   int mismatches, sums_due, sums_checked;
   int idle_pct      = 0;
   int stall_pct     = 0;
   int items_sent    = 0;
   int setups_loaded = 0;
   int phases_run    = 0;
   int quiet_cycles  = 0;
   int frame_w, frame_h, frame_b;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   conv2d_3x3_stride_pad dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   conv_sum_checker sum_check (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tlast    (rsp_tlast),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .mismatches   (mismatches),
      .sums_due     (sums_due),
      .sums_checked (sums_checked)
   );

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QuietLimit) begin
         $display("watchdog: no transfer for %0d cycles", QuietLimit);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   function automatic int clamp(input int v, input int lo, input int hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   function automatic logic [PixBits-1:0] any_pixel();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return PixBits'($urandom);
      endcase
   endfunction

   function automatic logic [CoefRowBits-1:0] random_coef_row();
      logic [CoefRowBits-1:0] v;
      case ($urandom_range(0, 5))
         0: v = {3{16'h7fff}};
         1: v = {3{16'h8000}};
         2: begin
            for (int j = 0; j < 3; j++)
               v[SlotBits*j +: SlotBits] = SlotBits'($urandom_range(0, 512) - 256);
         end
         default: v = CoefRowBits'({$urandom, $urandom});
      endcase
      return v;
   endfunction

   task automatic csr_write(input csr_index_type idx, input logic [CoefRowBits-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic load_setup(input int w, input int h, input int b, input int s,
                             input logic [CoefRowBits-1:0] top,
                             input logic [CoefRowBits-1:0] mid,
                             input logic [CoefRowBits-1:0] bot);
      csr_write(CsrWidth, CoefRowBits'(w));
      csr_write(CsrHeight, CoefRowBits'(h));
      csr_write(CsrBorder, CoefRowBits'(b));
      csr_write(CsrStep, CoefRowBits'(s));
      csr_write(CsrCoefTop, top);
      csr_write(CsrCoefMid, mid);
      csr_write(CsrCoefBot, bot);
      csr_valid <= 1'b0;
      frame_w = clamp(int'(w[ColBits-1:0]), 1, MaxWidth);
      frame_h = clamp(int'(h[RowBits-1:0]), 1, MaxHeight);
      frame_b = clamp(int'(b[BorderBits-1:0]), 0, BorderMax);
      setups_loaded++;
   endtask

   task automatic send_item(input pixel_op_type op, input logic [PixBits-1:0] pixel);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= pixel;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      items_sent++;
   endtask

   // one full frame: real rows then bottom border flushes, a few of them swapped
   task automatic send_frame(input int noise_pct);
      bit swap;
      for (int r = 0; r < frame_h + frame_b; r++)
         for (int c = 0; c < frame_w; c++) begin
            swap = ($urandom_range(0, 99) < noise_pct);
            if ((r < frame_h) != swap)
               send_item(OpPixel, any_pixel());
            else
               send_item(OpFlush, any_pixel());
         end
   endtask

   task automatic send_run(input int n);
      repeat (n) send_item(($urandom_range(0, 9) == 0) ? OpFlush : OpPixel, any_pixel());
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      while (sums_due != 0) @(negedge clock);
      repeat (DrainCycles) @(negedge clock);
   endtask

   initial begin
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // largest and smallest possible sums
      load_setup(3, 3, 0, 1, {3{16'h7fff}}, {3{16'h7fff}}, {3{16'h7fff}});
      repeat (9) send_item(OpPixel, 8'hff);
      settle();
      load_setup(3, 3, 0, 1, {3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}});
      repeat (9) send_item(OpPixel, 8'hff);
      settle();

      // flush inside a real row, real pixel inside the bottom border
      load_setup(2, 2, 1, 2, random_coef_row(), random_coef_row(), random_coef_row());
      send_item(OpPixel, 8'h80);
      send_item(OpFlush, 8'h7f);
      send_item(OpPixel, 8'h01);
      send_item(OpPixel, 8'hfe);
      send_item(OpPixel, 8'h55);
      send_item(OpFlush, 8'haa);
      settle();

      // out-of-range registers clamp to a 1x1 frame, border 2, stride 1
      load_setup(0, 0, 3, 0, random_coef_row(), random_coef_row(), random_coef_row());
      send_item(OpPixel, 8'hc3);
      send_item(OpFlush, 8'h00);
      send_item(OpFlush, 8'hff);
      settle();

      while (items_sent < 400 || phases_run < 16) begin
         case ((phases_run + phases_run / 4) % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 77; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 77; end
            default: begin idle_pct = 18; stall_pct = 18; end
         endcase
         if (phases_run % 4 == 3) begin
            // largest geometries, only partly fed
            case ((phases_run / 4) % 4)
               0: load_setup(2047, 2, 1, $urandom_range(1, 4),
                             random_coef_row(), random_coef_row(), random_coef_row());
               1: load_setup(1024, 3, 2, 7,
                             random_coef_row(), random_coef_row(), random_coef_row());
               2: load_setup(4, 8191, 1, 1,
                             random_coef_row(), random_coef_row(), random_coef_row());
               default: load_setup(3, 4096, 0, 5,
                                   random_coef_row(), random_coef_row(), random_coef_row());
            endcase
            send_run(20);
         end else begin
            load_setup($urandom_range(0, 8), $urandom_range(0, 6), $urandom_range(0, 3),
                       $urandom_range(0, 7),
                       random_coef_row(), random_coef_row(), random_coef_row());
            repeat ($urandom_range(1, 2)) send_frame($urandom_range(0, 1) ? 10 : 0);
         end
         settle();
         phases_run++;
      end

      $display("sent %0d pixel and flush transfers over %0d register setups, checked %0d sums",
               items_sent, setups_loaded, sums_checked);
      $display("frames from 1x1 up to 1024 wide and 4096 high, border 0..2, stride 1..4");
      if (mismatches == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

>>> sim.f
sv/cv2_pkg.sv
sv/cv2_ram.sv
sv/cv2_mac.sv
sv/conv2d_3x3_stride_pad.sv
test/cv2_test_pkg.sv
test/conv_sum_checker.sv
test/tb.sv
